// File: design/reserved_range_carver_defines.svh
// Assertion macros shared by the reserved range carver modules.
`ifndef RESERVED_RANGE_CARVER_DEFINES_SVH
`define RESERVED_RANGE_CARVER_DEFINES_SVH

`ifndef ASSERT_OFF

// Checks a property on every rising clock edge outside reset.
`define RRC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("reserved_range_carver: assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define RRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("reserved_range_carver: assertion failed");

`else

`define RRC_ASSERT(lbl, clk, rstn, prop)
`define RRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/rrc_pkg.sv
// Shared constants and controller/datapath interface types for the range carver.
`timescale 1ns / 1ps

package rrc_pkg;

    // Default depth of the reserved range table
    localparam int DEFAULT_ENTRIES = 32;

    // Operation codes carried on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CARVE  = 1'b1;

    // Result status codes carried on the output tuser
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_PIECE    = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;        // latch input base and saturated end
        logic       rd_en;       // read table entry
        logic       wr_en;       // write table entry
        logic       wr_new;      // write the latched range, else the read entry
        logic       walk_step;   // carve: consume the entry in the read register
        logic       tail;        // carve: emit the piece from cur to end
        logic       flush;       // carve: emit the held piece as last, or no-free
        logic       resp;        // emit a single status transaction
        logic [1:0] resp_status; // status for resp
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;    // output register can take a transaction this cycle
        logic pend_valid;  // a free piece is held back
        logic cur_lt_end;  // carve cursor below region end
        logic walk_piece;  // current entry leaves a free piece in front of it
        logic rd_gt_new;   // read entry base above the base being inserted
    } dp_sts_t;

endpackage

// File: design/rrc_datapath.sv
// Datapath: range table memory, carve cursor, held piece and output register.
`timescale 1ns / 1ps
`include "reserved_range_carver_defines.svh"

module rrc_datapath #(
    parameter int ENTRIES = rrc_pkg::DEFAULT_ENTRIES,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  rrc_pkg::dp_cmd_t cmd,
    input  logic [AW-1:0]    rd_addr,
    input  logic [AW-1:0]    wr_addr,
    input  logic [63:0]      in_base,
    input  logic [63:0]      in_len,
    output rrc_pkg::dp_sts_t sts,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [127:0]     m_tdata,   // piece_base [63:0], piece_length [127:64]
    output logic [1:0]       m_tuser,   // status [1:0]
    output logic             m_tlast
);

    // Range table: base and saturated end of each reserved range
    logic [63:0] mem_base [ENTRIES];
    logic [63:0] mem_end  [ENTRIES];

    logic [63:0] rd_base_reg;
    logic [63:0] rd_end_reg;
    logic [63:0] cur_reg;
    logic [63:0] end_reg;
    logic        pend_valid_reg;
    logic [63:0] pend_base_reg;
    logic [63:0] pend_len_reg;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [63:0] out_base_reg;
    logic [63:0] out_len_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        skip;
    logic        piece;
    logic        produce;
    logic [63:0] sub_a;
    logic [63:0] piece_len;
    logic [63:0] cur_next;
    logic [64:0] end_sum;
    logic [63:0] end_sat;
    logic        load_out;
    logic [1:0]  o_status;
    logic [63:0] o_base;
    logic [63:0] o_len;
    logic        o_last;

    // Saturated end of the input range
    assign end_sum = {1'b0, in_base} + {1'b0, in_len};
    assign end_sat = end_sum[64] ? '1 : end_sum[63:0];

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem_base[wr_addr] <= cmd.wr_new ? cur_reg : rd_base_reg;
            mem_end[wr_addr]  <= cmd.wr_new ? end_reg : rd_end_reg;
        end
        if (cmd.rd_en) begin
            rd_base_reg <= mem_base[rd_addr];
            rd_end_reg  <= mem_end[rd_addr];
        end
    end

    // Per-entry carve decision: empty, behind the cursor or past the end
    assign skip  = (rd_end_reg <= rd_base_reg) || (rd_end_reg <= cur_reg) ||
                   (rd_base_reg >= end_reg);
    assign piece = !skip && (rd_base_reg > cur_reg);
    assign cur_next = (rd_end_reg < end_reg) ? rd_end_reg : end_reg;

    // Piece length: up to the entry base while walking, up to the end for the tail
    assign sub_a     = cmd.tail ? end_reg : rd_base_reg;
    assign piece_len = sub_a - cur_reg;
    assign produce   = (cmd.walk_step && piece) || cmd.tail;

    // Cursor and region end; for an insert they hold the new base and end
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg <= in_base;
            end_reg <= end_sat;
        end else if (cmd.walk_step && !skip) begin
            cur_reg <= cur_next;
        end
    end

    // Held piece: released once it is known whether another one follows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (produce) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (produce) begin
            pend_base_reg <= cur_reg;
            pend_len_reg  <= piece_len;
        end
    end

    // Output transaction select
    always_comb begin
        load_out = 1'b0;
        o_status = rrc_pkg::ST_PIECE;
        o_base   = pend_base_reg;
        o_len    = pend_len_reg;
        o_last   = 1'b0;
        if (produce && pend_valid_reg) begin
            load_out = 1'b1;
        end else if (cmd.flush) begin
            load_out = 1'b1;
            o_last   = 1'b1;
            if (!pend_valid_reg) begin
                o_status = rrc_pkg::ST_NONE;
                o_base   = '0;
                o_len    = '0;
            end
        end else if (cmd.resp) begin
            load_out = 1'b1;
            o_status = cmd.resp_status;
            o_base   = '0;
            o_len    = '0;
            o_last   = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_status_reg <= o_status;
            out_base_reg   <= o_base;
            out_len_reg    <= o_len;
            out_last_reg   <= o_last;
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    assign sts.out_free   = out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.cur_lt_end = cur_reg < end_reg;
    assign sts.walk_piece = piece;
    assign sts.rd_gt_new  = rd_base_reg > cur_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_base_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    // A waiting transaction is never overwritten
    `RRC_ASSERT(a_no_overwrite, aclk, aresetn, !load_out || out_free)
    // A held piece is always released by the next tail or flush, never dropped
    `RRC_ASSERT_NEXT(a_flush_clears, aclk, aresetn, cmd.flush, !pend_valid_reg)
    // A tail piece is only taken while the cursor is below the end
    `RRC_ASSERT(a_tail_nonempty, aclk, aresetn, !cmd.tail || (cur_reg < end_reg))

endmodule

// File: design/rrc_ctrl.sv
// Controller: sequences table inserts and carve walks over the datapath.
`timescale 1ns / 1ps
`include "reserved_range_carver_defines.svh"

module rrc_ctrl #(
    parameter int ENTRIES = rrc_pkg::DEFAULT_ENTRIES,
    parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             s_op,
    output rrc_pkg::dp_cmd_t cmd,
    output logic [AW-1:0]    rd_addr,
    output logic [AW-1:0]    wr_addr,
    input  rrc_pkg::dp_sts_t sts
);

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(ENTRIES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CWALK  = 3'd1;
    localparam logic [2:0] S_CTAIL  = 3'd2;
    localparam logic [2:0] S_CFLUSH = 3'd3;
    localparam logic [2:0] S_IWALK  = 3'd4;
    localparam logic [2:0] S_IPLACE = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [1:0]    resp_reg, resp_next;
    logic          accept;
    logic          walk_last;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    // Current carve entry is the last one in the table
    assign walk_last = (CW'(idx_reg) + CW'(1)) == cnt_reg;

    // Next state and commands
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        resp_next       = resp_reg;
        cmd             = '0;
        cmd.resp_status = resp_reg;
        rd_addr         = idx_reg;
        wr_addr         = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (s_op == rrc_pkg::OP_CARVE) begin
                        if (cnt_reg == '0) begin
                            state_next = S_CTAIL;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            state_next = S_CWALK;
                        end
                    end else if (cnt_reg == CNT_FULL) begin
                        resp_next  = rrc_pkg::ST_FULL;
                        state_next = S_RESP;
                    end else if (cnt_reg == '0) begin
                        idx_next   = '0;
                        state_next = S_IPLACE;
                    end else begin
                        // walk down from the top, shifting larger bases up
                        cmd.rd_en  = 1'b1;
                        rd_addr    = AW'(cnt_reg - CW'(1));
                        idx_next   = AW'(cnt_reg);
                        state_next = S_IWALK;
                    end
                end
            end
            S_CWALK: begin
                if (!sts.cur_lt_end) begin
                    state_next = S_CTAIL;
                end else if (sts.walk_piece && sts.pend_valid && !sts.out_free) begin
                    state_next = S_CWALK;
                end else begin
                    cmd.walk_step = 1'b1;
                    if (walk_last) begin
                        state_next = S_CTAIL;
                    end else begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg + AW'(1);
                        idx_next  = idx_reg + AW'(1);
                    end
                end
            end
            S_CTAIL: begin
                if (!sts.cur_lt_end) begin
                    state_next = S_CFLUSH;
                end else if (!sts.pend_valid || sts.out_free) begin
                    cmd.tail   = 1'b1;
                    state_next = S_CFLUSH;
                end
            end
            S_CFLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_IWALK: begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt_new) begin
                    // entry below moves up one slot
                    if (idx_reg == AW'(1)) begin
                        idx_next   = '0;
                        state_next = S_IPLACE;
                    end else begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg - AW'(2);
                        idx_next  = idx_reg - AW'(1);
                    end
                end else begin
                    cmd.wr_new = 1'b1;
                    cnt_next   = cnt_reg + CW'(1);
                    resp_next  = rrc_pkg::ST_INSERTED;
                    state_next = S_RESP;
                end
            end
            S_IPLACE: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_new = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                resp_next  = rrc_pkg::ST_INSERTED;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        resp_reg <= resp_next;
    end

    // Table fill never exceeds its depth
    `RRC_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_FULL)
    // A read and a write in the same cycle never touch the same entry
    `RRC_ASSERT(a_rw_apart, aclk, aresetn,
        !(cmd.rd_en && cmd.wr_en) || (rd_addr != wr_addr))
    // A carve walk only runs over a non-empty table
    `RRC_ASSERT(a_walk_nonempty, aclk, aresetn,
        (state_reg != S_CWALK) || (cnt_reg != '0))

endmodule

// File: design/reserved_range_carver.sv
// Top level of the reserved range carver: stream ports, controller and datapath.
//
// Usage: the input stream carries one operation per transaction. tuser[0] selects
// insert (0) or carve (1); tdata holds base_address and range_length. An insert
// places the range into a table sorted by base address and returns one
// transaction with status inserted, or table full when the table holds
// RESERVED_ENTRIES ranges already. A carve subtracts every reserved range from
// the given region and returns the free pieces in ascending order, status free
// piece, with tlast on the final one; when nothing is free it returns a single
// no-free transaction. Range ends saturate at the top of the address space.
// Timing: one operation is worked on at a time, and a carve walk reads the table
// memory once per cycle while the output does not stall it. s_tready is high only
// between operations.
// Reset empties the table and drops m_tvalid; s_tready is high once reset is seen.
// When the receiver stalls, results wait in the output register and the walk
// pauses at the next piece.
`timescale 1ns / 1ps

module reserved_range_carver #(
    parameter int RESERVED_ENTRIES = rrc_pkg::DEFAULT_ENTRIES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // base_address [63:0], range_length [127:64]
    input  logic [0:0]   s_tuser,   // operation [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // piece_base [63:0], piece_length [127:64]
    output logic [1:0]   m_tuser,   // status [1:0]
    output logic         m_tlast    // last_piece
);

    localparam int AW = (RESERVED_ENTRIES > 1) ? $clog2(RESERVED_ENTRIES) : 1;

    rrc_pkg::dp_cmd_t cmd;
    rrc_pkg::dp_sts_t sts;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;

    // Sequencer for inserts and carve walks
    rrc_ctrl #(
        .ENTRIES (RESERVED_ENTRIES),
        .AW      (AW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .sts      (sts)
    );

    // Table, cursor arithmetic and output register
    rrc_datapath #(
        .ENTRIES (RESERVED_ENTRIES),
        .AW      (AW)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .in_base  (s_tdata[63:0]),
        .in_len   (s_tdata[127:64]),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/reserved_range_carver_tb.sv
// Self-checking testbench for the reserved range carver: directed table, then random traffic.
`timescale 1ns / 1ps

module reserved_range_carver_tb;

    localparam int          ENTRIES     = rrc_pkg::DEFAULT_ENTRIES;
    localparam int          RANDOM_OPS  = 260;
    localparam int          QUIET_OPS   = 40;
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_CYCLES = ENTRIES + 8;
    localparam logic [63:0] TOP_ADDR    = 64'hFFFF_FFFF_FFFF_FFFF;

    // One result transaction as seen on the master side
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] pbase;
        logic [63:0] plen;
        logic        last;
    } piece_t;

    // One row of the directed table
    typedef struct packed {
        logic        op;
        logic [63:0] base;
        logic [63:0] len;
        logic        typed;
        piece_t      want;
    } row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;   // base_address [63:0], range_length [127:64]
    logic [0:0]   s_tuser  = '0;   // operation [0]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;         // piece_base [63:0], piece_length [127:64]
    logic [1:0]   m_tuser;         // status [1:0]
    logic         m_tlast;

    // Predictor copy of the reserved table
    logic [63:0] rsv_base [ENTRIES];
    logic [63:0] rsv_len  [ENTRIES];
    int          rsv_count = 0;

    piece_t awaited_pieces[$];
    piece_t step_results[$];
    row_t   directed_rows[$];

    int  errors      = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  quiet       = 1'b0;

    reserved_range_carver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // End of a half-open range, clamped at the top of the address space
    function automatic logic [63:0] sat_end(input logic [63:0] b, input logic [63:0] l);
        logic [64:0] sum;
        sum = {1'b0, b} + {1'b0, l};
        return sum[64] ? TOP_ADDR : sum[63:0];
    endfunction

    function automatic piece_t mk_piece(input logic [1:0] st, input logic [63:0] pb,
                                        input logic [63:0] pl, input logic last);
        piece_t p;
        p.status = st;
        p.pbase  = pb;
        p.plen   = pl;
        p.last   = last;
        return p;
    endfunction

    // Applies one operation to the table copy and leaves its results in step_results
    task automatic predict_range_op(input logic op, input logic [63:0] base,
                                    input logic [63:0] len);
        int          pos;
        logic [63:0] cur;
        logic [63:0] stop;
        logic [63:0] rs;
        logic [63:0] re;
        piece_t      tmp;
        step_results.delete();
        if (op == rrc_pkg::OP_INSERT) begin
            if (rsv_count >= ENTRIES) begin
                step_results.push_back(mk_piece(rrc_pkg::ST_FULL, '0, '0, 1'b1));
            end else begin
                pos = 0;
                while (pos < rsv_count && rsv_base[pos] <= base) pos++;
                for (int i = rsv_count; i > pos; i--) begin
                    rsv_base[i] = rsv_base[i-1];
                    rsv_len[i]  = rsv_len[i-1];
                end
                rsv_base[pos] = base;
                rsv_len[pos]  = len;
                rsv_count++;
                step_results.push_back(mk_piece(rrc_pkg::ST_INSERTED, '0, '0, 1'b1));
            end
        end else begin
            cur  = base;
            stop = sat_end(base, len);
            for (int i = 0; i < rsv_count && cur < stop; i++) begin
                rs = rsv_base[i];
                re = sat_end(rs, rsv_len[i]);
                // zero length, behind the cursor, or beyond the region: no effect
                if (re <= rs || re <= cur || rs >= stop) continue;
                if (rs > cur) begin
                    step_results.push_back(mk_piece(rrc_pkg::ST_PIECE, cur, rs - cur, 1'b0));
                end
                cur = (re < stop) ? re : stop;
            end
            if (cur < stop) begin
                step_results.push_back(mk_piece(rrc_pkg::ST_PIECE, cur, stop - cur, 1'b0));
            end
            if (step_results.size() == 0) begin
                step_results.push_back(mk_piece(rrc_pkg::ST_NONE, '0, '0, 1'b1));
            end else begin
                tmp = step_results.pop_back();
                tmp.last = 1'b1;
                step_results.push_back(tmp);
            end
        end
    endtask

    task automatic add_row(input logic op, input logic [63:0] base, input logic [63:0] len,
                           input logic typed, input logic [1:0] st,
                           input logic [63:0] pb, input logic [63:0] pl);
        row_t r;
        r.op    = op;
        r.base  = base;
        r.len   = len;
        r.typed = typed;
        r.want  = mk_piece(st, pb, pl, 1'b1);
        directed_rows.push_back(r);
    endtask

    // Drives one transaction and records what it should produce once accepted
    task automatic send_op(input logic op, input logic [63:0] base, input logic [63:0] len,
                           input logic typed, input piece_t want);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {len, base};
        do @(posedge aclk); while (!s_tready);
        predict_range_op(op, base, len);
        if (typed) begin
            awaited_pieces.push_back(want);
        end else begin
            foreach (step_results[k]) awaited_pieces.push_back(step_results[k]);
        end
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (awaited_pieces.size() != 0) @(posedge aclk);
    endtask

    // Address mix: a busy window, the top of memory, full-width noise, extremes
    function automatic logic [63:0] pick_addr();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 64'h1_0000 + 64'($urandom_range(0, 16'hFFFF));
        if (sel < 72) return TOP_ADDR - 64'($urandom_range(0, 16'hFFFF));
        if (sel < 90) return {$urandom, $urandom};
        if (sel < 95) return '0;
        return TOP_ADDR;
    endfunction

    function automatic logic [63:0] pick_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55) return 64'($urandom_range(1, 16'h0FFF));
        if (sel < 65) return '0;
        if (sel < 75) return 64'($urandom_range(0, 16'hFFFF));
        if (sel < 88) return {$urandom, $urandom};
        return TOP_ADDR;
    endfunction

    // Receiver: random stall bursts, none in the quiet tail
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && aresetn && $urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker: each transaction against the oldest expectation
    always @(posedge aclk) begin : result_check
        piece_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_pieces.size() == 0) begin
                $error("unexpected result: status %0d base %h length %h last %0b",
                       m_tuser, m_tdata[63:0], m_tdata[127:64], m_tlast);
                errors++;
            end else begin
                want = awaited_pieces.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, m_tuser);
                    errors++;
                end
                if (m_tdata[63:0] !== want.pbase) begin
                    $error("piece_base mismatch: expected %h, got %h",
                           want.pbase, m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[127:64] !== want.plen) begin
                    $error("piece_length mismatch: expected %h, got %h",
                           want.plen, m_tdata[127:64]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_piece mismatch: expected %0b, got %0b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("reserved_range_carver regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial begin
        logic        op;
        logic [63:0] base;
        logic [63:0] len;
        piece_t      none_want;
        none_want = '0;

        // empty table: empty region, whole space, saturated empty region at the top, plain region
        add_row(rrc_pkg::OP_CARVE, 64'h0, 64'h0, 1'b1, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h0, TOP_ADDR, 1'b1, rrc_pkg::ST_PIECE, '0, TOP_ADDR);
        add_row(rrc_pkg::OP_CARVE, TOP_ADDR, TOP_ADDR, 1'b1, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h1000, 64'h100, 1'b1, rrc_pkg::ST_PIECE,
                64'h1000, 64'h100);
        // overlapping, zero-length, equal-base and saturating reservations
        add_row(rrc_pkg::OP_INSERT, 64'h2000, 64'h100, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        add_row(rrc_pkg::OP_INSERT, 64'h2800, 64'h0, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        add_row(rrc_pkg::OP_INSERT, 64'h1F80, 64'h100, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        add_row(rrc_pkg::OP_INSERT, 64'h2000, 64'h40, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        add_row(rrc_pkg::OP_INSERT, 64'h3000, TOP_ADDR, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        add_row(rrc_pkg::OP_INSERT, TOP_ADDR, TOP_ADDR, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        add_row(rrc_pkg::OP_INSERT, 64'h0, 64'h10, 1'b1, rrc_pkg::ST_INSERTED, '0, '0);
        // carves against that table
        add_row(rrc_pkg::OP_CARVE, 64'h1000, 64'h3000, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h2000, 64'h80, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h0, TOP_ADDR, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, TOP_ADDR - 64'h10, 64'h20, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h2800, 64'h10, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h0, 64'h8, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h5, 64'h20, 1'b0, rrc_pkg::ST_NONE, '0, '0);
        add_row(rrc_pkg::OP_CARVE, 64'h2FFF, 64'h1, 1'b0, rrc_pkg::ST_NONE, '0, '0);

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[r]) begin
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 3));
            send_op(directed_rows[r].op, directed_rows[r].base, directed_rows[r].len,
                    directed_rows[r].typed, directed_rows[r].want);
        end
        pause_sender(1);
        wait_drained();

        // random traffic, mostly carves, most of them over the busy window
        for (int i = 0; i < RANDOM_OPS; i++) begin
            if (i == RANDOM_OPS - QUIET_OPS) quiet = 1'b1;
            if (i == RANDOM_OPS / 2) begin
                pause_sender(1);
                wait_drained();
            end
            if ($urandom_range(0, 99) < 30) begin
                op   = rrc_pkg::OP_INSERT;
                base = pick_addr();
                len  = pick_len();
            end else begin
                op = rrc_pkg::OP_CARVE;
                if ($urandom_range(0, 99) < 70) begin
                    base = 64'h1_0000 - 64'($urandom_range(0, 16'h0FFF));
                    len  = 64'h1_0000 + 64'($urandom_range(0, 16'h1FFF));
                end else begin
                    base = pick_addr();
                    len  = pick_len();
                end
            end
            if (!quiet && $urandom_range(0, 4) == 0) pause_sender($urandom_range(1, 3));
            send_op(op, base, len, 1'b0, none_want);
        end
        pause_sender(1);

        // drain, then a quiet window to catch stray results
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && awaited_pieces.size() == 0) begin
            $display("reserved_range_carver regression: pass");
        end else begin
            $display("reserved_range_carver regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/rrc_pkg.sv
design/rrc_datapath.sv
design/rrc_ctrl.sv
design/reserved_range_carver.sv
tb/reserved_range_carver_tb.sv
